// ===== rtl/sfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpe_pkg
// Shared types, constants and arithmetic helpers for the sphere field
// potential evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpe_pkg;

  localparam int QB        = 30;
  localparam int LANES     = 6;
  localparam int DIV_STEPS = 30;
  localparam int SQ_STEPS  = 31;
  localparam int LAM_STEPS = 62;

  localparam logic [31:0] Q_ONE = 32'd1 << QB;

  localparam int L_W  = 0;
  localparam int L_XX = 1;
  localparam int L_YY = 2;
  localparam int L_ZZ = 3;
  localparam int L_XY = 4;
  localparam int L_XZ = 5;

  localparam logic [1:0] CFG_FIELD  = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_RATIO  = 2'd2;
  localparam logic [1:0] CFG_MODE   = 2'd3;

  localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

  typedef struct packed {
    logic                      vld;
    logic [63:0]               den;
    logic [LANES-1:0][63:0]    rem;
    logic [LANES-1:0][QB-1:0]  quo;
    logic [LANES-1:0]          full;
    logic                      zero;
    logic                      in_sph;
    logic [2:0]                sgn;
    logic [31:0]               dx;
  } div_t;

  typedef struct packed {
    logic        vld;
    logic [60:0] rad;
    logic [61:0] root;
    logic [30:0] w;
    logic [33:0] p;
    logic [31:0] cxy;
    logic [31:0] cxz;
    logic [31:0] dx;
    logic        in_sph;
  } sq_t;

  typedef struct packed {
    logic clip;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [31:0] phi;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic        in_sph;
    logic        sat;
  } res_t;

  function automatic logic [31:0] mag_s32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic logic [33:0] mag_s34(input logic signed [33:0] a);
    return a[33] ? 34'(-a) : 34'(a);
  endfunction

  function automatic logic signed [64:0] rnd_shift(input logic [63:0] mag, input logic neg,
                                                   input int unsigned sh);
    logic [64:0] sum;
    sum = ({1'b0, mag} + (65'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(sum) : $signed(sum);
  endfunction

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t o;
    if (v > SAT_MAX) begin
      o.clip = 1'b1;
      o.val  = 32'h7fff_ffff;
    end else if (v < SAT_MIN) begin
      o.clip = 1'b1;
      o.val  = 32'h8000_0000;
    end else begin
      o.clip = 1'b0;
      o.val  = v[31:0];
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t s);
    div_t        o;
    logic [64:0] t;
    o = s;
    for (int i = 0; i < LANES; i++) begin
      t = {s.rem[i], 1'b0};
      if (t >= {1'b0, s.den}) begin
        o.rem[i] = 64'(t - {1'b0, s.den});
        o.quo[i] = {s.quo[i][QB-2:0], 1'b1};
      end else begin
        o.rem[i] = t[63:0];
        o.quo[i] = {s.quo[i][QB-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic sq_t sq_step(input sq_t s, input int k);
    sq_t         o;
    logic [61:0] bitv;
    logic [61:0] trial;
    o     = s;
    bitv  = 62'd1 << (2 * (SQ_STEPS - 1 - k));
    trial = s.root + bitv;
    if ({1'b0, s.rad} >= trial) begin
      o.rad  = 61'({1'b0, s.rad} - trial);
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sphere_in_field_potential_eval.sv =====
// Path: front stages s0-s3, divider lanes, square root, back end a0-a8, output register.
// Throughput: one point per cycle while in_ready is high, set by the 30-stage divider
// lanes and the 31-stage square root pipeline.
// A two-entry output register/skid decouples stalls. A configuration write recomputes
// lambda in a bit-serial divider; in_ready is held low until lam_r is updated.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// sphere_in_field_potential_eval
// Pipelined evaluator of the potential and gradient around a sphere of another
// conductivity in a uniform field along x, in 3-D or (mode bit clear) 2-D with z forced to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_in_field_potential_eval #(
  parameter int FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [31:0] in_offset_x,
  input  wire signed [31:0] in_offset_y,
  input  wire signed [31:0] in_offset_z,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] out_potential,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic signed [31:0] out_grad_z,
  output logic              out_inside_sphere,
  output logic              out_saturated,
  input  wire               cfg_we,
  input  wire [1:0]         cfg_index,
  input  wire [31:0]        cfg_wdata
);

  localparam int DS = sfpe_pkg::DIV_STEPS;
  localparam int SS = sfpe_pkg::SQ_STEPS;
  localparam int NL = sfpe_pkg::LANES;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  // configuration
  logic signed [31:0] field_r;
  logic [30:0]        radius_r;
  logic [30:0]        ratio_r;
  logic               d3_r;

  // lambda divider
  logic               lam_busy_r;
  logic               lam_load_r;
  logic [5:0]         lam_cnt_r;
  logic [31:0]        lam_rem_r;
  logic [61:0]        lam_dq_r;
  logic [31:0]        lam_den_r;
  logic               lam_neg_r;
  logic signed [31:0] lam_r;
  logic signed [32:0] lam_num;
  logic [31:0]        lam_num_mag;
  logic [31:0]        lam_den;
  logic [32:0]        lam_t;

  logic en;
  logic in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r  <= $signed(ONE);
      radius_r <= ONE[30:0];
      ratio_r  <= ONE[30:0];
      d3_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sfpe_pkg::CFG_FIELD:  field_r  <= $signed(cfg_wdata);
        sfpe_pkg::CFG_RADIUS: radius_r <= cfg_wdata[30:0];
        sfpe_pkg::CFG_RATIO:  ratio_r  <= cfg_wdata[30:0];
        sfpe_pkg::CFG_MODE:   d3_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lam_num     = $signed({2'b00, ONE[30:0]}) - $signed({2'b00, ratio_r});
    lam_num_mag = lam_num[32] ? 32'(-lam_num) : 32'(lam_num);
    lam_den     = (d3_r ? {ONE[30:0], 1'b0} : ONE) + {1'b0, ratio_r};
    lam_t       = {lam_rem_r, lam_dq_r[61]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_busy_r <= 1'b0;
      lam_load_r <= 1'b0;
      lam_r      <= '0;
    end else if (cfg_we) begin
      lam_busy_r <= 1'b1;
      lam_load_r <= 1'b1;
    end else if (lam_busy_r) begin
      if (lam_load_r) begin
        lam_load_r <= 1'b0;
        lam_cnt_r  <= 6'(sfpe_pkg::LAM_STEPS);
        lam_rem_r  <= '0;
        lam_den_r  <= lam_den;
        lam_neg_r  <= lam_num[32];
        lam_dq_r   <= ({30'd0, lam_num_mag} << sfpe_pkg::QB) + 62'(lam_den >> 1);
      end else if (lam_cnt_r != 6'd0) begin
        lam_cnt_r <= lam_cnt_r - 6'd1;
        if (lam_t >= {1'b0, lam_den_r}) begin
          lam_rem_r <= 32'(lam_t - {1'b0, lam_den_r});
          lam_dq_r  <= {lam_dq_r[60:0], 1'b1};
        end else begin
          lam_rem_r <= lam_t[31:0];
          lam_dq_r  <= {lam_dq_r[60:0], 1'b0};
        end
      end else begin
        lam_busy_r <= 1'b0;
        lam_r      <= lam_neg_r ? $signed(32'd0 - lam_dq_r[31:0]) : $signed(lam_dq_r[31:0]);
      end
    end
  end

  // front: input, magnitudes, products, r^2
  logic               s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r;
  logic signed [31:0] s0_dx_r, s0_dy_r, s0_dz_r;
  logic [31:0]        s1_ux_r, s1_uy_r, s1_uz_r, s1_dx_r;
  logic [2:0]         s1_sgn_r, s2_sgn_r, s3_sgn_r;
  logic [NL-1:0][63:0] s2_n_r, s3_n_r;
  logic [31:0]        s2_dx_r, s3_dx_r;
  logic [63:0]        s3_r2_r;

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_xfer;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx_r  <= in_offset_x;
      s0_dy_r  <= in_offset_y;
      s0_dz_r  <= d3_r ? in_offset_z : 32'sd0;
      s1_ux_r  <= sfpe_pkg::mag_s32(s0_dx_r);
      s1_uy_r  <= sfpe_pkg::mag_s32(s0_dy_r);
      s1_uz_r  <= sfpe_pkg::mag_s32(s0_dz_r);
      s1_dx_r  <= s0_dx_r;
      s1_sgn_r <= {s0_dz_r[31], s0_dy_r[31], s0_dx_r[31]};
      s2_n_r[sfpe_pkg::L_W]  <= 64'(radius_r) * 64'(radius_r);
      s2_n_r[sfpe_pkg::L_XX] <= 64'(s1_ux_r) * 64'(s1_ux_r);
      s2_n_r[sfpe_pkg::L_YY] <= 64'(s1_uy_r) * 64'(s1_uy_r);
      s2_n_r[sfpe_pkg::L_ZZ] <= 64'(s1_uz_r) * 64'(s1_uz_r);
      s2_n_r[sfpe_pkg::L_XY] <= 64'(s1_ux_r) * 64'(s1_uy_r);
      s2_n_r[sfpe_pkg::L_XZ] <= 64'(s1_ux_r) * 64'(s1_uz_r);
      s2_dx_r  <= s1_dx_r;
      s2_sgn_r <= s1_sgn_r;
      s3_r2_r  <= s2_n_r[sfpe_pkg::L_XX] + s2_n_r[sfpe_pkg::L_YY] + s2_n_r[sfpe_pkg::L_ZZ];
      s3_n_r   <= s2_n_r;
      s3_dx_r  <= s2_dx_r;
      s3_sgn_r <= s2_sgn_r;
    end
  end

  // divider lanes
  sfpe_pkg::div_t div_r   [DS+1];
  sfpe_pkg::div_t div_nxt [DS+1];

  always_comb begin
    div_nxt[0].vld    = s3_vld_r;
    div_nxt[0].den    = s3_r2_r;
    div_nxt[0].rem    = s3_n_r;
    div_nxt[0].quo    = '0;
    div_nxt[0].zero   = (s3_r2_r == 64'd0);
    div_nxt[0].in_sph = (s3_n_r[sfpe_pkg::L_W] > s3_r2_r);
    div_nxt[0].sgn    = s3_sgn_r;
    div_nxt[0].dx     = s3_dx_r;
    for (int i = 0; i < NL; i++) begin
      div_nxt[0].full[i] = (s3_n_r[i] >= s3_r2_r);
    end
    for (int k = 1; k <= DS; k++) begin
      div_nxt[k] = sfpe_pkg::div_step(div_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DS; k++) div_r[k].vld <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= DS; k++) div_r[k] <= div_nxt[k];
    end
  end

  // ratio fixup and square root
  sfpe_pkg::sq_t sq_r   [SS+1];
  sfpe_pkg::sq_t sq_nxt [SS+1];

  always_comb begin
    logic [NL-1:0][30:0] fr;
    for (int i = 0; i < NL; i++) begin
      if (div_r[DS].zero) fr[i] = '0;
      else if (div_r[DS].full[i]) fr[i] = sfpe_pkg::Q_ONE[30:0];
      else fr[i] = {1'b0, div_r[DS].quo[i]};
    end
    sq_nxt[0].vld    = div_r[DS].vld;
    sq_nxt[0].rad    = {fr[sfpe_pkg::L_W], 30'd0};
    sq_nxt[0].root   = '0;
    sq_nxt[0].w      = fr[sfpe_pkg::L_W];
    sq_nxt[0].p      = d3_r ? 34'({fr[sfpe_pkg::L_XX], 1'b0}) - 34'(fr[sfpe_pkg::L_YY])
                              - 34'(fr[sfpe_pkg::L_ZZ])
                            : 34'(fr[sfpe_pkg::L_XX]) - 34'(fr[sfpe_pkg::L_YY]);
    sq_nxt[0].cxy    = (div_r[DS].sgn[0] != div_r[DS].sgn[1]) ?
                       32'd0 - 32'(fr[sfpe_pkg::L_XY]) : 32'(fr[sfpe_pkg::L_XY]);
    sq_nxt[0].cxz    = (div_r[DS].sgn[0] != div_r[DS].sgn[2]) ?
                       32'd0 - 32'(fr[sfpe_pkg::L_XZ]) : 32'(fr[sfpe_pkg::L_XZ]);
    sq_nxt[0].dx     = div_r[DS].dx;
    sq_nxt[0].in_sph = div_r[DS].in_sph;
    for (int k = 1; k <= SS; k++) begin
      sq_nxt[k] = sfpe_pkg::sq_step(sq_r[k-1], k - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SS; k++) sq_r[k].vld <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= SS; k++) sq_r[k] <= sq_nxt[k];
    end
  end

  // back end arithmetic
  logic a0_vld_r, a1_vld_r, a2_vld_r, a3_vld_r, a4_vld_r;
  logic a5_vld_r, a6_vld_r, a7_vld_r, a8_vld_r;

  logic [61:0]        a0_qp_r;
  logic [30:0]        a0_w_r;
  logic signed [33:0] a0_p_r, a1_p_r, a2_p_r, a3_p_r;
  logic signed [31:0] a0_cxy_r, a1_cxy_r, a2_cxy_r, a3_cxy_r;
  logic signed [31:0] a0_cxz_r, a1_cxz_r, a2_cxz_r, a3_cxz_r;
  logic signed [31:0] a0_dx_r, a1_dx_r, a2_dx_r, a3_dx_r, a4_dx_r, a5_dx_r, a6_dx_r;
  logic a0_in_r, a1_in_r, a2_in_r, a3_in_r, a4_in_r, a5_in_r, a6_in_r, a7_in_r, a8_in_r;
  logic [30:0]        a1_q_r;
  logic [61:0]        a2_mp_r;
  logic signed [31:0] a3_m_r;
  logic [63:0]        a4_pmp_r, a4_pmxy_r, a4_pmxz_r;
  logic               a4_nmp_r, a4_nmxy_r, a4_nmxz_r;
  logic [31:0]        a4_qm_r;
  logic signed [32:0] a5_mpr_r;
  logic signed [31:0] a5_mxy_r, a5_mxz_r;
  logic [63:0]        a5_gp_r;
  logic signed [33:0] a6_gxa_r, a6_gya_r, a6_gza_r, a6_g_r, a7_g_r;
  logic [63:0]        a7_pgx_r, a7_pgy_r, a7_pgz_r, a7_pphi_r;
  logic               a7_ngx_r, a7_ngy_r, a7_ngz_r, a7_nphi_r;
  logic signed [64:0] a8_phi_r, a8_gx_r, a8_gy_r, a8_gz_r;

  logic [31:0]        e_mag;
  logic               e_pos;
  logic signed [33:0] xy34, xz34;

  assign e_mag = sfpe_pkg::mag_s32(field_r);
  assign e_pos = (field_r > 32'sd0);
  assign xy34  = 34'(a5_mxy_r);
  assign xz34  = 34'(a5_mxz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_vld_r <= 1'b0;
      a1_vld_r <= 1'b0;
      a2_vld_r <= 1'b0;
      a3_vld_r <= 1'b0;
      a4_vld_r <= 1'b0;
      a5_vld_r <= 1'b0;
      a6_vld_r <= 1'b0;
      a7_vld_r <= 1'b0;
      a8_vld_r <= 1'b0;
    end else if (en) begin
      a0_vld_r <= sq_r[SS].vld;
      a1_vld_r <= a0_vld_r;
      a2_vld_r <= a1_vld_r;
      a3_vld_r <= a2_vld_r;
      a4_vld_r <= a3_vld_r;
      a5_vld_r <= a4_vld_r;
      a6_vld_r <= a5_vld_r;
      a7_vld_r <= a6_vld_r;
      a8_vld_r <= a7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_qp_r  <= 62'(sq_r[SS].w) * 62'(sq_r[SS].root[30:0]);
      a0_w_r   <= sq_r[SS].w;
      a0_p_r   <= $signed(sq_r[SS].p);
      a0_cxy_r <= $signed(sq_r[SS].cxy);
      a0_cxz_r <= $signed(sq_r[SS].cxz);
      a0_dx_r  <= $signed(sq_r[SS].dx);
      a0_in_r  <= sq_r[SS].in_sph;

      a1_q_r   <= d3_r ? 31'(sfpe_pkg::rnd_shift(64'(a0_qp_r), 1'b0, sfpe_pkg::QB)) : a0_w_r;
      a1_p_r   <= a0_p_r;
      a1_cxy_r <= a0_cxy_r;
      a1_cxz_r <= a0_cxz_r;
      a1_dx_r  <= a0_dx_r;
      a1_in_r  <= a0_in_r;

      a2_mp_r  <= 62'(sfpe_pkg::mag_s32(lam_r)) * 62'(a1_q_r);
      a2_p_r   <= a1_p_r;
      a2_cxy_r <= a1_cxy_r;
      a2_cxz_r <= a1_cxz_r;
      a2_dx_r  <= a1_dx_r;
      a2_in_r  <= a1_in_r;

      a3_m_r   <= a2_in_r ? lam_r :
                  32'(sfpe_pkg::rnd_shift(64'(a2_mp_r), lam_r[31], sfpe_pkg::QB));
      a3_p_r   <= a2_p_r;
      a3_cxy_r <= a2_cxy_r;
      a3_cxz_r <= a2_cxz_r;
      a3_dx_r  <= a2_dx_r;
      a3_in_r  <= a2_in_r;

      a4_pmp_r  <= 64'(sfpe_pkg::mag_s32(a3_m_r)) * 64'(sfpe_pkg::mag_s34(a3_p_r));
      a4_pmxy_r <= 64'(sfpe_pkg::mag_s32(a3_m_r)) * 64'(sfpe_pkg::mag_s32(a3_cxy_r));
      a4_pmxz_r <= 64'(sfpe_pkg::mag_s32(a3_m_r)) * 64'(sfpe_pkg::mag_s32(a3_cxz_r));
      a4_nmp_r  <= a3_m_r[31] != a3_p_r[33];
      a4_nmxy_r <= a3_m_r[31] != a3_cxy_r[31];
      a4_nmxz_r <= a3_m_r[31] != a3_cxz_r[31];
      a4_qm_r   <= 32'($signed({1'b0, sfpe_pkg::Q_ONE}) + 33'(a3_m_r));
      a4_dx_r   <= a3_dx_r;
      a4_in_r   <= a3_in_r;

      a5_mpr_r <= 33'(sfpe_pkg::rnd_shift(a4_pmp_r, a4_nmp_r, sfpe_pkg::QB));
      a5_mxy_r <= 32'(sfpe_pkg::rnd_shift(a4_pmxy_r, a4_nmxy_r, sfpe_pkg::QB));
      a5_mxz_r <= 32'(sfpe_pkg::rnd_shift(a4_pmxz_r, a4_nmxz_r, sfpe_pkg::QB));
      a5_gp_r  <= 64'(e_mag) * 64'(a4_qm_r);
      a5_dx_r  <= a4_dx_r;
      a5_in_r  <= a4_in_r;

      a6_gxa_r <= 34'(a5_mpr_r) - $signed(34'(sfpe_pkg::Q_ONE));
      a6_gya_r <= d3_r ? (xy34 <<< 1) + xy34 : (xy34 <<< 1);
      a6_gza_r <= d3_r ? (xz34 <<< 1) + xz34 : (xz34 <<< 1);
      a6_g_r   <= 34'(sfpe_pkg::rnd_shift(a5_gp_r, e_pos, sfpe_pkg::QB));
      a6_dx_r  <= a5_dx_r;
      a6_in_r  <= a5_in_r;

      a7_pgx_r  <= 64'(e_mag) * 64'(sfpe_pkg::mag_s34(a6_gxa_r));
      a7_pgy_r  <= 64'(e_mag) * 64'(sfpe_pkg::mag_s34(a6_gya_r));
      a7_pgz_r  <= 64'(e_mag) * 64'(sfpe_pkg::mag_s34(a6_gza_r));
      a7_pphi_r <= 64'(sfpe_pkg::mag_s34(a6_g_r)) * 64'(sfpe_pkg::mag_s32(a6_dx_r));
      a7_ngx_r  <= field_r[31] != a6_gxa_r[33];
      a7_ngy_r  <= field_r[31] != a6_gya_r[33];
      a7_ngz_r  <= field_r[31] != a6_gza_r[33];
      a7_nphi_r <= a6_g_r[33] != a6_dx_r[31];
      a7_g_r    <= a6_g_r;
      a7_in_r   <= a6_in_r;

      a8_phi_r <= sfpe_pkg::rnd_shift(a7_pphi_r, a7_nphi_r, FRAC_BITS);
      a8_gx_r  <= a7_in_r ? 65'(a7_g_r) :
                  sfpe_pkg::rnd_shift(a7_pgx_r, a7_ngx_r, sfpe_pkg::QB);
      a8_gy_r  <= a7_in_r ? 65'sd0 :
                  sfpe_pkg::rnd_shift(a7_pgy_r, a7_ngy_r, sfpe_pkg::QB);
      a8_gz_r  <= (a7_in_r || !d3_r) ? 65'sd0 :
                  sfpe_pkg::rnd_shift(a7_pgz_r, a7_ngz_r, sfpe_pkg::QB);
      a8_in_r  <= a7_in_r;
    end
  end

  // saturation, output register and skid
  sfpe_pkg::sat_t st_phi, st_gx, st_gy, st_gz;
  sfpe_pkg::res_t fin;
  sfpe_pkg::res_t out_r;
  sfpe_pkg::res_t sk_r;
  logic           out_vld_r;
  logic           sk_vld_r;
  logic           arrive;
  logic           out_free;

  always_comb begin
    st_phi     = sfpe_pkg::sat32(a8_phi_r);
    st_gx      = sfpe_pkg::sat32(a8_gx_r);
    st_gy      = sfpe_pkg::sat32(a8_gy_r);
    st_gz      = sfpe_pkg::sat32(a8_gz_r);
    fin.phi    = st_phi.val;
    fin.gx     = st_gx.val;
    fin.gy     = st_gy.val;
    fin.gz     = st_gz.val;
    fin.in_sph = a8_in_r;
    fin.sat    = st_phi.clip || st_gx.clip || st_gy.clip || st_gz.clip;
  end

  assign en       = !sk_vld_r;
  assign in_ready = en && !lam_busy_r;
  assign arrive   = a8_vld_r && en;
  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (out_free) begin
      if (sk_vld_r) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end else begin
        out_vld_r <= arrive;
      end
    end else if (arrive) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= sk_vld_r ? sk_r : fin;
    end else if (arrive) begin
      sk_r <= fin;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_potential     = $signed(out_r.phi);
  assign out_grad_x        = $signed(out_r.gx);
  assign out_grad_y        = $signed(out_r.gy);
  assign out_grad_z        = $signed(out_r.gz);
  assign out_inside_sphere = out_r.in_sph;
  assign out_saturated     = out_r.sat;

endmodule

`default_nettype wire

// ===== rtl/sfpe_checker.sv =====
// ----------------------------------------------------------------------------
// sfpe_checker
// Port-level checks for the sphere field potential evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpe_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_potential,
  input wire [31:0] out_grad_x,
  input wire [31:0] out_grad_y,
  input wire [31:0] out_grad_z,
  input wire        out_inside_sphere,
  input wire        out_saturated,
  input wire        cfg_we
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_potential))
    else $error("stalled result dropped or changed");

  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_sphere |-> out_grad_y == 32'd0 && out_grad_z == 32'd0)
    else $error("inside result with transverse gradient");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_potential != 32'h7fff_ffff && out_potential != 32'h8000_0000
    && out_grad_x != 32'h7fff_ffff && out_grad_x != 32'h8000_0000
    && out_grad_y != 32'h7fff_ffff && out_grad_y != 32'h8000_0000
    && out_grad_z != 32'h7fff_ffff && out_grad_z != 32'h8000_0000 |-> !out_saturated)
    else $error("saturated flag without a clipped value");

  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken while lambda is recomputed");

endmodule

bind sphere_in_field_potential_eval sfpe_checker u_sfpe_checker (.*);

`default_nettype wire
